// ===== design/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg
// Shared sizes, link and metadata types for the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int LINK_W = $clog2(SLOTS + 1);

	localparam int OP_W = 2;
	localparam int SLOT_W = 6;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_RESET = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_ACTIVE = 2'd1,
		ST_FULL       = 2'd2
	} status_t;

	typedef logic [LINK_W-1:0] link_t;

	localparam link_t NIL = LINK_W'(SLOTS);

	typedef struct packed {
		logic  active;
		logic  keep;
		link_t prev;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	typedef struct packed {
		logic  clear;
		logic  a_re;
		link_t a_raddr;
		logic  a_we;
		link_t a_waddr;
		link_t a_wdata;
		logic  b_re;
		link_t b_raddr;
		logic  b_we;
		link_t b_waddr;
		meta_t b_wdata;
	} link_req_t;

endpackage

// ===== design/slot_pool_allocator_lru_evict_top.sv =====
// ----------------------------------------------------------------------------
// slot_pool_allocator_lru_evict_top
// Fixed slot pool: LIFO free list plus newest-to-oldest active list, with
// eviction of the oldest slot, unless it is kept, when the pool is exhausted.
// ----------------------------------------------------------------------------
// One word in, one word out. The block handles one word at a time, stepping
// through a short read-modify-write sequence on the next-link and metadata
// memories, each with one read and one write port. A free unlinks the slot
// from the active list and pushes it on the free list; an allocate that
// evicts does the same for the oldest slot before it allocates from the
// free list. A free of an inactive slot or an allocate refused for a kept
// oldest slot ends after its first read. Pool reset is immediate: per-slot
// written flags make every entry read as its reset value, so no clearing
// sweep is needed. The next word is accepted as soon as the sequence is
// back at rest, even while the previous result still waits on the output.
module slot_pool_allocator_lru_evict_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [spa_pkg::OP_W-1:0]      op,
	input  logic [spa_pkg::SLOT_W-1:0]    slot,
	input  logic                          keep,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spa_pkg::STATUS_W-1:0]  status,
	output logic [spa_pkg::SLOT_W-1:0]    granted_slot,
	output logic                          evicted,
	output logic [spa_pkg::SLOT_W-1:0]    evicted_slot
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVCHK,
		S_RL1,
		S_RL2,
		S_RL3,
		S_AL0,
		S_AL1,
		S_AL2,
		S_RESP
	} state_t;

	state_t                          state_q;
	logic                            out_valid_q;
	spa_pkg::link_t                  free_head_q;
	spa_pkg::link_t                  newest_q;
	spa_pkg::link_t                  oldest_q;
	logic                            keep_q;
	logic                            ev_q;
	spa_pkg::link_t                  tgt_q;
	spa_pkg::link_t                  nxt_q;
	spa_pkg::link_t                  prv_q;
	spa_pkg::link_t                  nw_q;
	logic                            kn_q;
	spa_pkg::link_t                  gr_q;
	spa_pkg::status_t                st_q;
	spa_pkg::status_t                status_q;
	logic [spa_pkg::SLOT_W-1:0]      granted_q;
	logic                            evicted_q;
	logic [spa_pkg::SLOT_W-1:0]      evicted_slot_q;

	spa_pkg::link_req_t              req;
	spa_pkg::link_t                  a_rd;
	spa_pkg::meta_t                  b_rd;
	spa_pkg::link_t                  slot_l;
	logic                            slot_ok;
	logic                            release_ok;

	assign slot_l = spa_pkg::LINK_W'(slot);
	assign slot_ok = 32'(slot) < 32'(spa_pkg::SLOTS);
	assign release_ok = ev_q || b_rd.active;
	assign in_ready = (state_q == S_IDLE);

	spa_link_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.a_rd  (a_rd),
		.b_rd  (b_rd)
	);

	always_comb begin
		req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (spa_pkg::op_t'(op))
						spa_pkg::OP_RESET: req.clear = 1'b1;
						spa_pkg::OP_ALLOC: begin
							if (free_head_q == spa_pkg::NIL
								&& oldest_q != spa_pkg::NIL) begin
								req.b_re = 1'b1;
								req.b_raddr = oldest_q;
							end
						end
						spa_pkg::OP_FREE: begin
							req.a_re = slot_ok;
							req.a_raddr = slot_l;
							req.b_re = slot_ok;
							req.b_raddr = slot_l;
						end
						spa_pkg::OP_NONE: ;
					endcase
				end
			end
			S_EVCHK: begin
				req.a_re = 1'b1;
				req.a_raddr = oldest_q;
				req.b_re = 1'b1;
				req.b_raddr = oldest_q;
			end
			S_RL1: begin
				if (release_ok) begin
					req.a_we = (b_rd.prev != spa_pkg::NIL);
					req.a_waddr = b_rd.prev;
					req.a_wdata = a_rd;
					req.b_re = (a_rd != spa_pkg::NIL);
					req.b_raddr = a_rd;
				end
			end
			S_RL2: begin
				req.b_we = 1'b1;
				req.b_waddr = nxt_q;
				req.b_wdata = '{active: 1'b1, keep: b_rd.keep, prev: prv_q};
			end
			S_RL3: begin
				req.a_we = 1'b1;
				req.a_waddr = tgt_q;
				req.a_wdata = free_head_q;
				req.b_we = 1'b1;
				req.b_waddr = tgt_q;
				req.b_wdata = '{active: 1'b0, keep: 1'b0, prev: spa_pkg::NIL};
			end
			S_AL0: begin
				req.a_re = 1'b1;
				req.a_raddr = free_head_q;
				req.b_re = (newest_q != spa_pkg::NIL);
				req.b_raddr = newest_q;
			end
			S_AL1: begin
				req.a_we = 1'b1;
				req.a_waddr = free_head_q;
				req.a_wdata = newest_q;
				req.b_we = 1'b1;
				req.b_waddr = free_head_q;
				req.b_wdata = '{active: 1'b1, keep: keep_q, prev: spa_pkg::NIL};
			end
			S_AL2: begin
				req.b_we = 1'b1;
				req.b_waddr = nw_q;
				req.b_wdata = '{active: 1'b1, keep: kn_q, prev: gr_q};
			end
			S_RESP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			free_head_q <= '0;
			newest_q <= spa_pkg::NIL;
			oldest_q <= spa_pkg::NIL;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						keep_q <= keep;
						ev_q <= 1'b0;
						gr_q <= '0;
						unique case (spa_pkg::op_t'(op))
							spa_pkg::OP_RESET: begin
								free_head_q <= '0;
								newest_q <= spa_pkg::NIL;
								oldest_q <= spa_pkg::NIL;
								st_q <= spa_pkg::ST_OK;
								state_q <= S_RESP;
							end
							spa_pkg::OP_ALLOC: begin
								if (free_head_q != spa_pkg::NIL) begin
									st_q <= spa_pkg::ST_OK;
									state_q <= S_AL0;
								end else if (oldest_q == spa_pkg::NIL) begin
									st_q <= spa_pkg::ST_FULL;
									state_q <= S_RESP;
								end else begin
									st_q <= spa_pkg::ST_OK;
									state_q <= S_EVCHK;
								end
							end
							spa_pkg::OP_FREE: begin
								tgt_q <= slot_l;
								if (slot_ok) begin
									st_q <= spa_pkg::ST_OK;
									state_q <= S_RL1;
								end else begin
									st_q <= spa_pkg::ST_NOT_ACTIVE;
									state_q <= S_RESP;
								end
							end
							spa_pkg::OP_NONE: begin
								st_q <= spa_pkg::ST_OK;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_EVCHK: begin
					if (b_rd.keep) begin
						st_q <= spa_pkg::ST_FULL;
						state_q <= S_RESP;
					end else begin
						tgt_q <= oldest_q;
						ev_q <= 1'b1;
						state_q <= S_RL1;
					end
				end
				S_RL1: begin
					if (!release_ok) begin
						st_q <= spa_pkg::ST_NOT_ACTIVE;
						state_q <= S_RESP;
					end else begin
						nxt_q <= a_rd;
						prv_q <= b_rd.prev;
						if (b_rd.prev == spa_pkg::NIL) begin
							newest_q <= a_rd;
						end
						if (a_rd == spa_pkg::NIL) begin
							oldest_q <= b_rd.prev;
							state_q <= S_RL3;
						end else begin
							state_q <= S_RL2;
						end
					end
				end
				S_RL2: state_q <= S_RL3;
				S_RL3: begin
					free_head_q <= tgt_q;
					state_q <= ev_q ? S_AL0 : S_RESP;
				end
				S_AL0: state_q <= S_AL1;
				S_AL1: begin
					free_head_q <= a_rd;
					nw_q <= newest_q;
					kn_q <= b_rd.keep;
					gr_q <= free_head_q;
					newest_q <= free_head_q;
					if (newest_q == spa_pkg::NIL) begin
						oldest_q <= free_head_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_AL2;
					end
				end
				S_AL2: state_q <= S_RESP;
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						status_q <= st_q;
						granted_q <= spa_pkg::SLOT_W'(gr_q);
						evicted_q <= ev_q;
						evicted_slot_q <= ev_q ? spa_pkg::SLOT_W'(tgt_q) : '0;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign granted_slot = granted_q;
	assign evicted = evicted_q;
	assign evicted_slot = evicted_slot_q;

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(newest_q == spa_pkg::NIL) == (oldest_q == spa_pkg::NIL))
		else $error("active list ends disagree on emptiness");

	a_grant_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AL1 |-> free_head_q != spa_pkg::NIL)
		else $error("grant issued with empty free list");

	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evicted_q |-> status_q == spa_pkg::ST_OK)
		else $error("eviction reported with error status");

	a_pool_reset: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && spa_pkg::op_t'(op) == spa_pkg::OP_RESET |=>
		free_head_q == '0 && newest_q == spa_pkg::NIL && oldest_q == spa_pkg::NIL)
		else $error("pool reset did not restore list heads");

endmodule

// ===== design/spa_ram.sv =====
// ----------------------------------------------------------------------------
// spa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/spa_link_store.sv =====
// ----------------------------------------------------------------------------
// spa_link_store
// Next-link memory and metadata memory (active, keep, prev-link), with
// per-entry written flags that make unwritten entries read as reset values.
// ----------------------------------------------------------------------------
module spa_link_store (
	input  logic                clk,
	input  logic                arst_n,
	input  spa_pkg::link_req_t  req,
	output spa_pkg::link_t      a_rd,
	output spa_pkg::meta_t      b_rd
);

	logic [spa_pkg::SLOTS-1:0]  wa_q;
	logic [spa_pkg::SLOTS-1:0]  wb_q;
	logic                       fa_s1;
	logic                       fb_s1;
	spa_pkg::link_t             a_rst_s1;
	spa_pkg::link_t             a_ram;
	logic [spa_pkg::META_W-1:0] b_ram;

	spa_ram #(
		.WIDTH(spa_pkg::LINK_W),
		.DEPTH(spa_pkg::SLOTS)
	) u_next_ram (
		.clk  (clk),
		.we   (req.a_we),
		.waddr(req.a_waddr[spa_pkg::IDX_W-1:0]),
		.wdata(req.a_wdata),
		.re   (req.a_re),
		.raddr(req.a_raddr[spa_pkg::IDX_W-1:0]),
		.rdata(a_ram)
	);

	spa_ram #(
		.WIDTH(spa_pkg::META_W),
		.DEPTH(spa_pkg::SLOTS)
	) u_meta_ram (
		.clk  (clk),
		.we   (req.b_we),
		.waddr(req.b_waddr[spa_pkg::IDX_W-1:0]),
		.wdata(req.b_wdata),
		.re   (req.b_re),
		.raddr(req.b_raddr[spa_pkg::IDX_W-1:0]),
		.rdata(b_ram)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q <= '0;
			wb_q <= '0;
		end else if (req.clear) begin
			wa_q <= '0;
			wb_q <= '0;
		end else begin
			if (req.a_we) begin
				wa_q[req.a_waddr[spa_pkg::IDX_W-1:0]] <= 1'b1;
			end
			if (req.b_we) begin
				wb_q[req.b_waddr[spa_pkg::IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.a_re) begin
			fa_s1 <= wa_q[req.a_raddr[spa_pkg::IDX_W-1:0]];
			a_rst_s1 <= req.a_raddr + spa_pkg::LINK_W'(1);
		end
		if (req.b_re) begin
			fb_s1 <= wb_q[req.b_raddr[spa_pkg::IDX_W-1:0]];
		end
	end

	assign a_rd = fa_s1 ? a_ram : a_rst_s1;
	assign b_rd = fb_s1 ? spa_pkg::meta_t'(b_ram)
		: spa_pkg::meta_t'{active: 1'b0, keep: 1'b0, prev: spa_pkg::NIL};

endmodule

// ===== bench/slot_pool_allocator_lru_evict_top_test.sv =====
// ----------------------------------------------------------------------------
// slot_pool_allocator_lru_evict_top_test
// Self-checking bench for the slot pool allocator: a queue-fed driver offers
// pool reset, allocate and free words with random gaps, a shadow pool with its
// own free list and newest-to-oldest active list predicts every result word,
// and a monitor compares each result field by field under random output stalls.
// ----------------------------------------------------------------------------
module slot_pool_allocator_lru_evict_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_WORDS = 1950;
	localparam int LIMIT = 600000;
	localparam int DRAIN = 40;
	localparam int HOLD_LONG = 500;

	typedef struct packed {
		logic [spa_pkg::OP_W-1:0]   op;
		logic [spa_pkg::SLOT_W-1:0] slot;
		logic                       keep;
	} req_t;

	typedef struct packed {
		logic [spa_pkg::STATUS_W-1:0] status;
		logic [spa_pkg::SLOT_W-1:0]   granted_slot;
		logic                         evicted;
		logic [spa_pkg::SLOT_W-1:0]   evicted_slot;
	} grant_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [spa_pkg::OP_W-1:0] op = '0;
	logic [spa_pkg::SLOT_W-1:0] slot = '0;
	logic keep = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [spa_pkg::STATUS_W-1:0] status;
	logic [spa_pkg::SLOT_W-1:0] granted_slot;
	logic evicted;
	logic [spa_pkg::SLOT_W-1:0] evicted_slot;

	req_t req_queue[$];
	grant_t grant_queue[$];
	int errors = 0;
	int words_out = 0;
	int cycles = 0;
	int in_gap = 0;
	int out_hold = 0;
	int n_words = 0;

	// shadow pool
	spa_pkg::link_t succ[spa_pkg::SLOTS];
	spa_pkg::link_t pred[spa_pkg::SLOTS];
	logic busy[spa_pkg::SLOTS];
	logic pinned[spa_pkg::SLOTS];
	spa_pkg::link_t free_top;
	spa_pkg::link_t newest;
	spa_pkg::link_t oldest;

	slot_pool_allocator_lru_evict_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.slot(slot),
		.keep(keep),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_slot(granted_slot),
		.evicted(evicted),
		.evicted_slot(evicted_slot)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void pool_clear();
		for (int i = 0; i < spa_pkg::SLOTS; i++) begin
			succ[i] = spa_pkg::link_t'(i + 1);
			pred[i] = spa_pkg::NIL;
			busy[i] = 1'b0;
			pinned[i] = 1'b0;
		end
		free_top = '0;
		newest = spa_pkg::NIL;
		oldest = spa_pkg::NIL;
	endfunction

	function automatic void pool_release(spa_pkg::link_t s);
		spa_pkg::link_t p;
		spa_pkg::link_t n;
		p = pred[s];
		n = succ[s];
		if (p == spa_pkg::NIL) newest = n;
		else succ[p] = n;
		if (n == spa_pkg::NIL) oldest = p;
		else pred[n] = p;
		busy[s] = 1'b0;
		pinned[s] = 1'b0;
		pred[s] = spa_pkg::NIL;
		succ[s] = free_top;
		free_top = s;
	endfunction

	function automatic grant_t pool_apply(logic [spa_pkg::OP_W-1:0] r_op,
			logic [spa_pkg::SLOT_W-1:0] r_slot, logic r_keep);
		grant_t res;
		logic ok;
		spa_pkg::link_t s;
		res = '0;
		ok = 1'b1;
		case (r_op)
			spa_pkg::OP_RESET: begin
				pool_clear();
			end
			spa_pkg::OP_ALLOC: begin
				if (free_top == spa_pkg::NIL) begin
					if (oldest == spa_pkg::NIL || pinned[oldest]) begin
						ok = 1'b0;
						res.status = spa_pkg::ST_FULL;
					end else begin
						res.evicted = 1'b1;
						res.evicted_slot = oldest[spa_pkg::SLOT_W-1:0];
						pool_release(oldest);
					end
				end
				if (ok) begin
					s = free_top;
					free_top = succ[s];
					busy[s] = 1'b1;
					pinned[s] = r_keep;
					succ[s] = newest;
					pred[s] = spa_pkg::NIL;
					if (newest == spa_pkg::NIL) oldest = s;
					else pred[newest] = s;
					newest = s;
					res.granted_slot = s[spa_pkg::SLOT_W-1:0];
				end
			end
			spa_pkg::OP_FREE: begin
				if (!busy[r_slot]) res.status = spa_pkg::ST_NOT_ACTIVE;
				else pool_release(spa_pkg::link_t'(r_slot));
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic log_error(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic push_req(logic [spa_pkg::OP_W-1:0] r_op,
			logic [spa_pkg::SLOT_W-1:0] r_slot, logic r_keep);
		req_t r;
		r.op = r_op;
		r.slot = r_slot;
		r.keep = r_keep;
		req_queue.push_back(r);
		n_words++;
	endtask

	task automatic fill_pool(int keep_pct);
		int n;
		n = spa_pkg::SLOTS + $urandom_range(1, 6);
		push_req(spa_pkg::OP_RESET, 6'($urandom), 1'($urandom));
		for (int i = 0; i < n; i++)
			push_req(spa_pkg::OP_ALLOC, 6'($urandom), $urandom_range(0, 99) < keep_pct);
	endtask

	// driver: advance to the next word once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= '0;
			slot <= '0;
			keep <= 1'b0;
			in_gap <= 0;
		end else if (!in_valid || in_ready) begin
			req_t r;
			if (in_valid) grant_queue.push_back(pool_apply(op, slot, keep));
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (req_queue.size() != 0) begin
				r = req_queue.pop_front();
				op <= r.op;
				slot <= r.slot;
				keep <= r.keep;
				in_valid <= 1'b1;
				in_gap <= ((cycles / 400) % 3 == 0) ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus two long hold-offs to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_hold <= 0;
		end else if (cycles == 2500 || cycles == 9000) begin
			out_ready <= 1'b0;
			out_hold <= HOLD_LONG;
		end else if (out_hold > 0) begin
			out_ready <= 1'b0;
			out_hold <= out_hold - 1;
		end else if ((cycles / 700) % 3 == 1) begin
			out_ready <= 1'b1;
		end else begin
			int g;
			g = pick_gap();
			out_ready <= (g == 0);
			out_hold <= (g == 0) ? 0 : g - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			grant_t want;
			if (grant_queue.size() == 0) begin
				log_error($sformatf("word %0d arrived with nothing expected", words_out));
			end else begin
				want = grant_queue.pop_front();
				if (status !== want.status)
					log_error($sformatf("word %0d status got %0d want %0d",
						words_out, status, want.status));
				if (granted_slot !== want.granted_slot)
					log_error($sformatf("word %0d granted_slot got %0d want %0d",
						words_out, granted_slot, want.granted_slot));
				if (evicted !== want.evicted)
					log_error($sformatf("word %0d evicted got %0d want %0d",
						words_out, evicted, want.evicted));
				if (evicted_slot !== want.evicted_slot)
					log_error($sformatf("word %0d evicted_slot got %0d want %0d",
						words_out, evicted_slot, want.evicted_slot));
			end
			words_out++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[slot_pool_allocator_lru_evict_top] ERROR");
			$finish;
		end
	end

	initial begin
		int kind;
		int len;
		int pct;
		int r;
		pool_clear();

		// directed: inactive frees, LIFO reuse, kept and middle unlinks, unused op
		push_req(spa_pkg::OP_FREE, 6'd0, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd63, 1'b1);
		push_req(spa_pkg::OP_ALLOC, 6'd63, 1'b0);
		push_req(spa_pkg::OP_ALLOC, 6'd0, 1'b1);
		push_req(spa_pkg::OP_ALLOC, 6'd0, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd1, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd0, 1'b0);
		push_req(spa_pkg::OP_ALLOC, 6'd0, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd2, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd2, 1'b0);
		push_req(spa_pkg::OP_NONE, 6'd63, 1'b1);
		push_req(spa_pkg::OP_RESET, 6'd42, 1'b1);
		push_req(spa_pkg::OP_ALLOC, 6'd21, 1'b1);
		push_req(spa_pkg::OP_FREE, 6'd0, 1'b1);
		push_req(spa_pkg::OP_FREE, 6'd0, 1'b0);
		push_req(spa_pkg::OP_ALLOC, 6'd0, 1'b0);
		push_req(spa_pkg::OP_ALLOC, 6'd0, 1'b0);
		push_req(spa_pkg::OP_ALLOC, 6'd0, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd1, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd2, 1'b0);
		push_req(spa_pkg::OP_FREE, 6'd0, 1'b0);

		// full pool: kept oldest refuses, unkept oldest is evicted
		fill_pool(100);
		push_req(spa_pkg::OP_FREE, 6'd37, 1'b0);
		push_req(spa_pkg::OP_ALLOC, 6'd0, 1'b0);
		fill_pool(0);

		while (n_words < TARGET_WORDS) begin
			kind = $urandom_range(0, 9);
			r = $urandom_range(0, 3);
			pct = (r == 0) ? 0 : (r == 1) ? 5 : (r == 2) ? 50 : 100;
			if (kind == 0) begin
				fill_pool(pct);
			end else if (kind <= 4) begin
				len = $urandom_range(10, 60);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 199);
					if (r < 110)
						push_req(spa_pkg::OP_ALLOC, 6'($urandom),
							$urandom_range(0, 99) < pct);
					else if (r < 192)
						push_req(spa_pkg::OP_FREE, 6'($urandom), 1'($urandom));
					else if (r < 198)
						push_req(spa_pkg::OP_NONE, 6'($urandom), 1'($urandom));
					else
						push_req(spa_pkg::OP_RESET, 6'($urandom), 1'($urandom));
				end
			end else if (kind <= 6) begin
				len = $urandom_range(5, 40);
				for (int i = 0; i < len; i++)
					push_req(spa_pkg::OP_FREE, 6'($urandom), 1'($urandom));
			end else if (kind <= 8) begin
				len = $urandom_range(5, 80);
				for (int i = 0; i < len; i++)
					push_req(spa_pkg::OP_ALLOC, 6'($urandom), $urandom_range(0, 99) < pct);
			end else begin
				len = $urandom_range(5, 20);
				for (int i = 0; i < len; i++)
					push_req(2'($urandom), 6'($urandom), 1'($urandom));
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_queue.size() != 0 || in_valid || grant_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);

		if (errors == 0) $display("[slot_pool_allocator_lru_evict_top] OK");
		else $display("[slot_pool_allocator_lru_evict_top] ERROR");
		$finish;
	end

endmodule
